FILE: design/look_at_view_matrix_defines.svh
// ----------------------------------------------------------------------------
// look_at_view_matrix_defines
// Assertion macros shared by the checker of the look-at view matrix block.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LAV_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("look_at_view_matrix check failed");

// Consequent checked in the cycle after the antecedent.
`define LAV_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("look_at_view_matrix check failed");

`endif

FILE: design/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and constants of the look-at view matrix block.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Z     = 3'd5;

  typedef struct packed {
    logic signed [DATA_W-1:0] target_x;
    logic signed [DATA_W-1:0] target_y;
    logic signed [DATA_W-1:0] target_z;
    logic signed [DATA_W-1:0] up_hint_x;
    logic signed [DATA_W-1:0] up_hint_y;
    logic signed [DATA_W-1:0] up_hint_z;
  } lav_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] side_x;
    logic [DATA_W-1:0] side_y;
    logic [DATA_W-1:0] side_z;
    logic [DATA_W-1:0] ortho_up_x;
    logic [DATA_W-1:0] ortho_up_y;
    logic [DATA_W-1:0] ortho_up_z;
    logic [DATA_W-1:0] back_x;
    logic [DATA_W-1:0] back_y;
    logic [DATA_W-1:0] back_z;
    logic [DATA_W-1:0] shift_x;
    logic [DATA_W-1:0] shift_y;
    logic [DATA_W-1:0] shift_z;
  } lav_res_t;

endpackage

FILE: design/lav_cfg.sv
// ----------------------------------------------------------------------------
// lav_cfg
// Configuration registers: target point and up hint.
// ----------------------------------------------------------------------------
module lav_cfg #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lav_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [lav_pkg::DATA_W-1:0]     cfg_wdata,
  output lav_pkg::lav_cfg_t              cfg_q
);
  import lav_pkg::*;

  localparam logic [DATA_W-1:0] UP_Y_RST = DATA_W'(1) << FRAC_BITS;

  lav_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{target_x: '0, target_y: '0, target_z: '0,
                 up_hint_x: '0, up_hint_y: UP_Y_RST, up_hint_z: '0};
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TARGET_X: cfg_r.target_x  <= cfg_wdata;
        CFG_TARGET_Y: cfg_r.target_y  <= cfg_wdata;
        CFG_TARGET_Z: cfg_r.target_z  <= cfg_wdata;
        CFG_UP_X:     cfg_r.up_hint_x <= cfg_wdata;
        CFG_UP_Y:     cfg_r.up_hint_y <= cfg_wdata;
        CFG_UP_Z:     cfg_r.up_hint_z <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg_q = cfg_r;

endmodule

FILE: design/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalizer: magnitude alignment, bit-serial square root
// over stages and three restoring dividers over stages.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int IN_W      = 33,
  parameter int SIDE_W    = 96,
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic signed [IN_W-1:0]      v_in [3],
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_vld,
  output logic signed [FRAC_BITS+1:0] o_out [3],
  output logic [SIDE_W-1:0]           side_out
);
  import lav_pkg::*;

  localparam int PW = $clog2(IN_W);
  localparam int QW = FRAC_BITS + 1;
  localparam int OW = FRAC_BITS + 2;
  localparam int DW = FRAC_BITS + 33;
  localparam int RW = 32;
  localparam int TW = SIDE_W + 3;
  localparam int TZ = SIDE_W + 4;
  localparam logic [PW-1:0] TOP = PW'(30);

  logic [IN_W-1:0] ma_r [3];
  logic [TW-1:0]   ta_r;
  logic            va_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ma_r[i] <= v_in[i][IN_W-1] ? IN_W'(-v_in[i]) : IN_W'(v_in[i]);
      end
      ta_r <= {v_in[2][IN_W-1], v_in[1][IN_W-1], v_in[0][IN_W-1], side_in};
    end
  end

  logic [IN_W-1:0] mx01_c;
  logic [IN_W-1:0] mx_c;
  logic [IN_W-1:0] mb_r [3];
  logic [IN_W-1:0] mxb_r;
  logic [TW-1:0]   tb_r;
  logic            vb_r;

  assign mx01_c = (ma_r[0] > ma_r[1]) ? ma_r[0] : ma_r[1];
  assign mx_c   = (mx01_c > ma_r[2]) ? mx01_c : ma_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mb_r  <= ma_r;
      mxb_r <= mx_c;
      tb_r  <= ta_r;
    end
  end

  logic [PW-1:0]   p_c;
  logic [PW-1:0]   pc_r;
  logic [IN_W-1:0] mc_r [3];
  logic [TZ-1:0]   tc_r;
  logic            vc_r;

  always_comb begin
    p_c = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (mxb_r[i]) p_c = PW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r <= p_c;
      mc_r <= mb_r;
      tc_r <= {(mxb_r == '0), tb_r};
    end
  end

  logic [IN_W-1:0] sh_c [3];
  logic [30:0]     md_r [3];
  logic [TZ-1:0]   td_r;
  logic            vd_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pc_r > TOP) sh_c[i] = mc_r[i] >> (pc_r - TOP);
      else            sh_c[i] = mc_r[i] << (TOP - pc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) md_r[i] <= sh_c[i][30:0];
      td_r <= tc_r;
    end
  end

  logic [61:0]   sqe_r [3];
  logic [30:0]   me_r [3];
  logic [TZ-1:0] te_r;
  logic          ve_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sqe_r[i] <= md_r[i] * md_r[i];
      me_r <= md_r;
      te_r <= td_r;
    end
  end

  logic [63:0]   sx_r [0:RW];
  logic [31:0]   sr_r [0:RW];
  logic [30:0]   sm_r [0:RW][3];
  logic [TZ-1:0] st_r [0:RW];
  logic          sv_r [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r[0] <= 64'(sqe_r[0]) + 64'(sqe_r[1]) + 64'(sqe_r[2]);
      sr_r[0] <= '0;
      sm_r[0] <= me_r;
      st_r[0] <= te_r;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic [63:0] t_c;
    logic        ge_c;

    assign t_c  = (64'(sr_r[k]) << (B + 1)) + (64'd1 << (2 * B));
    assign ge_c = sx_r[k] >= t_c;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en) begin
        sv_r[k+1] <= sv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sx_r[k+1] <= ge_c ? (sx_r[k] - t_c) : sx_r[k];
        sr_r[k+1] <= ge_c ? (sr_r[k] | (32'd1 << B)) : sr_r[k];
        sm_r[k+1] <= sm_r[k];
        st_r[k+1] <= st_r[k];
      end
    end
  end

  logic [DW-1:0] drm_r [0:QW][3];
  logic [QW-1:0] dq_r  [0:QW][3];
  logic [31:0]   dl_r  [0:QW];
  logic [TZ-1:0] dt_r  [0:QW];
  logic          dv_r  [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= sv_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drm_r[0][i] <= DW'({sm_r[RW][i], {FRAC_BITS{1'b0}}}) + DW'(sr_r[RW] >> 1);
        dq_r[0][i]  <= '0;
      end
      dl_r[0] <= sr_r[RW];
      dt_r[0] <= st_r[RW];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int J = QW - 1 - k;
    logic [DW-1:0] dd_c;

    assign dd_c = DW'(dl_r[k]) << J;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (drm_r[k][i] >= dd_c) begin
            drm_r[k+1][i] <= drm_r[k][i] - dd_c;
            dq_r[k+1][i]  <= dq_r[k][i] | (QW'(1) << J);
          end else begin
            drm_r[k+1][i] <= drm_r[k][i];
            dq_r[k+1][i]  <= dq_r[k][i];
          end
        end
        dl_r[k+1] <= dl_r[k];
        dt_r[k+1] <= dt_r[k];
      end
    end
  end

  logic signed [OW-1:0] o_r [3];
  logic [SIDE_W-1:0]    os_r;
  logic                 ov_r;
  logic signed [OW-1:0] qs_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) qs_c[i] = $signed({1'b0, dq_r[QW][i]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dt_r[QW][SIDE_W+3])      o_r[i] <= '0;
        else if (dt_r[QW][SIDE_W+i]) o_r[i] <= -qs_c[i];
        else                         o_r[i] <= qs_c[i];
      end
      os_r <= dt_r[QW][SIDE_W-1:0];
    end
  end

  assign out_vld  = ov_r;
  assign o_out    = o_r;
  assign side_out = os_r;

endmodule

FILE: design/lav_frame.sv
// ----------------------------------------------------------------------------
// lav_frame
// Orthogonal up vector and translation terms of the view matrix, four stages.
// ----------------------------------------------------------------------------
module lav_frame #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    in_vld,
  input  logic signed [FRAC_BITS+1:0]             s_in [3],
  input  logic [96+3*(FRAC_BITS+2)-1:0]           side_in,
  output logic                                    out_vld,
  output lav_pkg::lav_res_t                       res
);
  import lav_pkg::*;

  localparam int OW  = FRAC_BITS + 2;
  localparam int UW  = FRAC_BITS + 3;
  localparam int UDW = 2 * OW + 1;
  localparam int SW  = FRAC_BITS + 37;
  localparam logic signed [UDW-1:0] UHALF = UDW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0]  SHALF = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0]  SMAX  = SW'(32'sh7fff_ffff);
  localparam logic signed [SW-1:0]  SMIN  = SW'(32'sh8000_0000);

  function automatic logic [DATA_W-1:0] sat_rnd(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] r;
    r = (x + SHALF) >>> FRAC_BITS;
    if (r > SMAX)      sat_rnd = 32'h7fff_ffff;
    else if (r < SMIN) sat_rnd = 32'h8000_0000;
    else               sat_rnd = r[DATA_W-1:0];
  endfunction

  logic signed [OW-1:0] fu [3];
  logic signed [31:0]   eu [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fu[i] = $signed(side_in[96 + OW*i +: OW]);
      eu[i] = $signed(side_in[32*i +: 32]);
    end
  end

  logic signed [OW-1:0]    s1_r [3];
  logic signed [OW-1:0]    f1_r [3];
  logic signed [31:0]      e1_r [3];
  logic signed [2*OW-1:0]  us1_r [6];
  logic signed [OW+31:0]   ds1_r [3];
  logic signed [OW+31:0]   df1_r [3];
  logic                    v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      us1_r[0] <= s_in[1] * fu[2];
      us1_r[1] <= s_in[2] * fu[1];
      us1_r[2] <= s_in[2] * fu[0];
      us1_r[3] <= s_in[0] * fu[2];
      us1_r[4] <= s_in[0] * fu[1];
      us1_r[5] <= s_in[1] * fu[0];
      for (int i = 0; i < 3; i++) begin
        ds1_r[i] <= s_in[i] * eu[i];
        df1_r[i] <= fu[i] * eu[i];
      end
      s1_r <= s_in;
      f1_r <= fu;
      e1_r <= eu;
    end
  end

  logic signed [UDW-1:0] ud_c [3];
  logic signed [UDW-1:0] ur_c [3];
  logic signed [SW-1:0]  ds_c;
  logic signed [SW-1:0]  df_c;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ud_c[j] = UDW'(us1_r[2*j]) - UDW'(us1_r[2*j+1]);
      ur_c[j] = (ud_c[j] + UHALF) >>> FRAC_BITS;
    end
    ds_c = SW'(ds1_r[0]) + SW'(ds1_r[1]) + SW'(ds1_r[2]);
    df_c = SW'(df1_r[0]) + SW'(df1_r[1]) + SW'(df1_r[2]);
  end

  logic signed [OW-1:0] s2_r [3];
  logic signed [OW-1:0] f2_r [3];
  logic signed [31:0]   e2_r [3];
  logic signed [UW-1:0] u2_r [3];
  logic [DATA_W-1:0]    shx2_r;
  logic [DATA_W-1:0]    shz2_r;
  logic                 v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) u2_r[j] <= UW'(ur_c[j]);
      shx2_r <= sat_rnd(-ds_c);
      shz2_r <= sat_rnd(df_c);
      s2_r   <= s1_r;
      f2_r   <= f1_r;
      e2_r   <= e1_r;
    end
  end

  logic signed [OW-1:0]    s3_r [3];
  logic signed [OW-1:0]    f3_r [3];
  logic signed [UW-1:0]    u3_r [3];
  logic signed [UW+31:0]   dp3_r [3];
  logic [DATA_W-1:0]       shx3_r;
  logic [DATA_W-1:0]       shz3_r;
  logic                    v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) dp3_r[i] <= u2_r[i] * e2_r[i];
      s3_r   <= s2_r;
      f3_r   <= f2_r;
      u3_r   <= u2_r;
      shx3_r <= shx2_r;
      shz3_r <= shz2_r;
    end
  end

  logic signed [SW-1:0] du_c;
  lav_res_t             res_r;
  logic                 v4_r;

  assign du_c = SW'(dp3_r[0]) + SW'(dp3_r[1]) + SW'(dp3_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.side_x     <= 32'(s3_r[0]);
      res_r.side_y     <= 32'(s3_r[1]);
      res_r.side_z     <= 32'(s3_r[2]);
      res_r.ortho_up_x <= 32'(u3_r[0]);
      res_r.ortho_up_y <= 32'(u3_r[1]);
      res_r.ortho_up_z <= 32'(u3_r[2]);
      res_r.back_x     <= 32'(-f3_r[0]);
      res_r.back_y     <= 32'(-f3_r[1]);
      res_r.back_z     <= 32'(-f3_r[2]);
      res_r.shift_x    <= shx3_r;
      res_r.shift_y    <= sat_rnd(-du_c);
      res_r.shift_z    <= shz3_r;
    end
  end

  assign out_vld = v4_r;
  assign res     = res_r;

endmodule

FILE: design/lav_skid.sv
// ----------------------------------------------------------------------------
// lav_skid
// Output register with one skid entry between the pipeline and the consumer.
// ----------------------------------------------------------------------------
module lav_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_vld,
  input  lav_pkg::lav_res_t up_data,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output lav_pkg::lav_res_t out_data
);
  import lav_pkg::*;

  lav_res_t out_r;
  lav_res_t skid_r;
  logic     out_vld_r;
  logic     skid_vld_r;
  logic     free_c;

  assign take   = !skid_vld_r;
  assign free_c = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (free_c) begin
      out_vld_r  <= skid_vld_r || up_vld;
      skid_vld_r <= 1'b0;
    end else if (up_vld && !skid_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (free_c) begin
      out_r <= skid_vld_r ? skid_r : up_data;
    end else if (!skid_vld_r) begin
      skid_r <= up_data;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

FILE: design/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one eye position per clock cycle while in_ready is high and returns
// the side, orthogonal up and back rows and the saturated translation terms
// of the view matrix for the configured target and up hint (Q16.16 at the
// default FRAC_BITS). Each of the two normalizers resolves its square root
// one bit per stage over 32 stages and its three divisions one quotient bit
// per stage over FRAC_BITS+1 stages. An output register with one skid entry
// keeps the block accepting while a result waits until that entry fills. The
// user must write configuration while idle; the block does not enforce it.
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lav_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [lav_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_eye_x,
  input  logic signed [31:0]            in_eye_y,
  input  logic signed [31:0]            in_eye_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_side_x,
  output logic signed [31:0]            out_side_y,
  output logic signed [31:0]            out_side_z,
  output logic signed [31:0]            out_ortho_up_x,
  output logic signed [31:0]            out_ortho_up_y,
  output logic signed [31:0]            out_ortho_up_z,
  output logic signed [31:0]            out_back_x,
  output logic signed [31:0]            out_back_y,
  output logic signed [31:0]            out_back_z,
  output logic signed [31:0]            out_shift_x,
  output logic signed [31:0]            out_shift_y,
  output logic signed [31:0]            out_shift_z
);
  import lav_pkg::*;

  localparam int OW      = FRAC_BITS + 2;
  localparam int CW      = OW + 33;
  localparam int SIDE2_W = 96 + 3 * OW;

  lav_cfg_t cfg;
  logic     pipe_en;

  lav_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_q     (cfg)
  );

  logic signed [32:0] d0_r [3];
  logic [95:0]        e0_r;
  logic               v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (pipe_en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d0_r[0] <= 33'(cfg.target_x) - 33'(in_eye_x);
      d0_r[1] <= 33'(cfg.target_y) - 33'(in_eye_y);
      d0_r[2] <= 33'(cfg.target_z) - 33'(in_eye_z);
      e0_r    <= {in_eye_z, in_eye_y, in_eye_x};
    end
  end

  logic                 n1_vld;
  logic signed [OW-1:0] f1 [3];
  logic [95:0]          e1;

  lav_norm #(.IN_W(33), .SIDE_W(96), .FRAC_BITS(FRAC_BITS)) u_norm_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (v0_r),
    .v_in     (d0_r),
    .side_in  (e0_r),
    .out_vld  (n1_vld),
    .o_out    (f1),
    .side_out (e1)
  );

  logic signed [OW+31:0] xp1_r [6];
  logic [SIDE2_W-1:0]    xs1_r;
  logic                  xv1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xv1_r <= 1'b0;
    end else if (pipe_en) begin
      xv1_r <= n1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      xp1_r[0] <= f1[1] * $signed(cfg.up_hint_z);
      xp1_r[1] <= f1[2] * $signed(cfg.up_hint_y);
      xp1_r[2] <= f1[2] * $signed(cfg.up_hint_x);
      xp1_r[3] <= f1[0] * $signed(cfg.up_hint_z);
      xp1_r[4] <= f1[0] * $signed(cfg.up_hint_y);
      xp1_r[5] <= f1[1] * $signed(cfg.up_hint_x);
      xs1_r    <= {f1[2], f1[1], f1[0], e1};
    end
  end

  logic signed [CW-1:0] c2_r [3];
  logic [SIDE2_W-1:0]   xs2_r;
  logic                 xv2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xv2_r <= 1'b0;
    end else if (pipe_en) begin
      xv2_r <= xv1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c2_r[0] <= CW'(xp1_r[0]) - CW'(xp1_r[1]);
      c2_r[1] <= CW'(xp1_r[2]) - CW'(xp1_r[3]);
      c2_r[2] <= CW'(xp1_r[4]) - CW'(xp1_r[5]);
      xs2_r   <= xs1_r;
    end
  end

  logic                 n2_vld;
  logic signed [OW-1:0] s2 [3];
  logic [SIDE2_W-1:0]   side2;

  lav_norm #(.IN_W(CW), .SIDE_W(SIDE2_W), .FRAC_BITS(FRAC_BITS)) u_norm_side (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (xv2_r),
    .v_in     (c2_r),
    .side_in  (xs2_r),
    .out_vld  (n2_vld),
    .o_out    (s2),
    .side_out (side2)
  );

  logic     fr_vld;
  lav_res_t fr_res;
  lav_res_t out_res;

  lav_frame #(.FRAC_BITS(FRAC_BITS)) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (n2_vld),
    .s_in    (s2),
    .side_in (side2),
    .out_vld (fr_vld),
    .res     (fr_res)
  );

  lav_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld    (fr_vld),
    .up_data   (fr_res),
    .take      (pipe_en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign in_ready       = pipe_en;
  assign out_side_x     = out_res.side_x;
  assign out_side_y     = out_res.side_y;
  assign out_side_z     = out_res.side_z;
  assign out_ortho_up_x = out_res.ortho_up_x;
  assign out_ortho_up_y = out_res.ortho_up_y;
  assign out_ortho_up_z = out_res.ortho_up_z;
  assign out_back_x     = out_res.back_x;
  assign out_back_y     = out_res.back_y;
  assign out_back_z     = out_res.back_z;
  assign out_shift_x    = out_res.shift_x;
  assign out_shift_y    = out_res.shift_y;
  assign out_shift_z    = out_res.shift_z;

endmodule

FILE: design/lav_check.sv
// ----------------------------------------------------------------------------
// lav_check
// Port-level checks of the look-at view matrix block, bound to the top level.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"

module lav_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_side_x,
  input logic [31:0] out_ortho_up_x,
  input logic [31:0] out_back_x,
  input logic [31:0] out_back_y,
  input logic [31:0] out_back_z,
  input logic [31:0] out_shift_x,
  input logic [31:0] out_shift_y,
  input logic [31:0] out_shift_z
);

  `LAV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  `LAV_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_shift_x) && $stable(out_side_x))

  `LAV_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

  `LAV_ASSERT_NOW(a_zero_forward, clk, rst_n, out_valid && out_back_x == 0 && out_back_y == 0 && out_back_z == 0, out_side_x == 0 && out_ortho_up_x == 0 && out_shift_x == 0 && out_shift_y == 0 && out_shift_z == 0)

endmodule

bind look_at_view_matrix lav_check u_lav_check (.*);

FILE: bench/tb_look_at_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix
// Self-checking bench for the look-at view matrix block.
// ----------------------------------------------------------------------------
// Eye positions are streamed through the valid/ready input channel while the
// result channel stalls at random. A fixed-point view matrix predictor in the
// bench computes each expected row set from the current target and up hint;
// only the first three rows of the short directed table that opens the run
// carry their own. Then several register settings (random, extremes, zero up
// hint, axis-aligned up hints) get random eyes; the final phase never idles.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix;
  import lav_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 2 * FB + 89;
  localparam int STALL_LIMIT = 4000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;

  typedef struct {
    logic signed [31:0] x, y, z;
    bit typed;
    lav_res_t res;
  } eye_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_side_x, out_side_y, out_side_z;
  logic signed [31:0] out_ortho_up_x, out_ortho_up_y, out_ortho_up_z;
  logic signed [31:0] out_back_x, out_back_y, out_back_z;
  logic signed [31:0] out_shift_x, out_shift_y, out_shift_z;

  logic signed [31:0] cam_regs [6];
  lav_res_t matrix_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int ready_hold = 0;
  bit quiet = 1'b0;
  string field_names[12] = '{"side_x", "side_y", "side_z", "ortho_up_x", "ortho_up_y",
                             "ortho_up_z", "back_x", "back_y", "back_z", "shift_x",
                             "shift_y", "shift_z"};

  look_at_view_matrix uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_eye_x(in_eye_x), .in_eye_y(in_eye_y), .in_eye_z(in_eye_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_side_x(out_side_x), .out_side_y(out_side_y), .out_side_z(out_side_z),
    .out_ortho_up_x(out_ortho_up_x), .out_ortho_up_y(out_ortho_up_y),
    .out_ortho_up_z(out_ortho_up_z),
    .out_back_x(out_back_x), .out_back_y(out_back_y), .out_back_z(out_back_z),
    .out_shift_x(out_shift_x), .out_shift_y(out_shift_y), .out_shift_z(out_shift_z)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= acc + bitv) begin
        x -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  function automatic void unit_vec(input longint v[3], output longint o[3]);
    longint unsigned mag[3], peak, sum, len, q;
    peak = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (peak >= (64'd1 << 31)) begin
      peak >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (peak < (64'd1 << 30)) begin
      peak <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FB) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic longint round_fx(longint v);
    return (v + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return MAXV;
    if (v < -64'sd2147483648) return MINV;
    return v[31:0];
  endfunction

  function automatic lav_res_t view_matrix(logic signed [31:0] ex, logic signed [31:0] ey,
                                           logic signed [31:0] ez);
    longint e[3], d[3], f[3], h[3], c[3], s[3], u[3];
    longint ds, du, df;
    lav_res_t r;
    e = '{ex, ey, ez};
    for (int i = 0; i < 3; i++) begin
      h[i] = cam_regs[3 + i];
      d[i] = longint'(cam_regs[i]) - e[i];
    end
    unit_vec(d, f);
    c[0] = f[1] * h[2] - f[2] * h[1];
    c[1] = f[2] * h[0] - f[0] * h[2];
    c[2] = f[0] * h[1] - f[1] * h[0];
    unit_vec(c, s);
    u[0] = round_fx(s[1] * f[2] - s[2] * f[1]);
    u[1] = round_fx(s[2] * f[0] - s[0] * f[2]);
    u[2] = round_fx(s[0] * f[1] - s[1] * f[0]);
    ds = s[0] * e[0] + s[1] * e[1] + s[2] * e[2];
    du = u[0] * e[0] + u[1] * e[1] + u[2] * e[2];
    df = f[0] * e[0] + f[1] * e[1] + f[2] * e[2];
    r.side_x = s[0][31:0];
    r.side_y = s[1][31:0];
    r.side_z = s[2][31:0];
    r.ortho_up_x = u[0][31:0];
    r.ortho_up_y = u[1][31:0];
    r.ortho_up_z = u[2][31:0];
    r.back_x = 32'(-f[0]);
    r.back_y = 32'(-f[1]);
    r.back_z = 32'(-f[2]);
    r.shift_x = clamp32(round_fx(-ds));
    r.shift_y = clamp32(round_fx(-du));
    r.shift_z = clamp32(round_fx(df));
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < 6) cam_regs[idx] = val;
    @(posedge clk);
  endtask

  task automatic set_camera(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                            logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
    write_reg(CFG_TARGET_X, tx);
    write_reg(CFG_TARGET_Y, ty);
    write_reg(CFG_TARGET_Z, tz);
    write_reg(CFG_UP_X, ux);
    write_reg(CFG_UP_Y, uy);
    write_reg(CFG_UP_Z, uz);
  endtask

  task automatic wait_empty();
    while (matrix_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_empty();
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_eye(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
                          bit typed, lav_res_t res);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_eye_x <= x;
    in_eye_y <= y;
    in_eye_z <= z;
    do @(posedge clk); while (!in_ready);
    matrix_q.push_back(typed ? res : view_matrix(x, y, z));
    items_sent++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return MAXV;
      1: return MINV;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'h1;
      5, 6: return $urandom_range(0, 1) ? ($urandom_range(0, 32'h40000)) :
                   -($urandom_range(0, 32'h40000));
      default: return $urandom();
    endcase
  endfunction

  task automatic random_eyes(int count);
    logic signed [31:0] x, y, z;
    int m;
    lav_res_t none;
    none = '0;
    for (int n = 0; n < count; n++) begin
      m = int'($urandom_range(0, 8)) - 4;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin x = $urandom(); y = $urandom(); z = $urandom(); end
        4, 5: begin
          x = cam_regs[0] + $urandom_range(0, 32'h80000) - 32'h40000;
          y = cam_regs[1] + $urandom_range(0, 32'h80000) - 32'h40000;
          z = cam_regs[2] + $urandom_range(0, 32'h80000) - 32'h40000;
        end
        6: begin x = cam_regs[0]; y = cam_regs[1]; z = cam_regs[2]; end
        7: begin
          x = cam_regs[0] - m * cam_regs[3];
          y = cam_regs[1] - m * cam_regs[4];
          z = cam_regs[2] - m * cam_regs[5];
        end
        default: begin x = pick_word(); y = pick_word(); z = pick_word(); end
      endcase
      send_eye(x, y, z, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= rst_n;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lav_res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_side_x, out_side_y, out_side_z, out_ortho_up_x, out_ortho_up_y,
             out_ortho_up_z, out_back_x, out_back_y, out_back_z, out_shift_x,
             out_shift_y, out_shift_z};
      results_seen++;
      if (matrix_q.size() == 0) begin
        $display("%0t: result with no pending expectation", $realtime);
        errors++;
      end else begin
        want = matrix_q.pop_front();
        for (int i = 0; i < 12; i++) begin
          if (got[(11 - i) * 32 +: 32] !== want[(11 - i) * 32 +: 32]) begin
            $display("%0t: %s expected %h actual %h", $realtime, field_names[i],
                     want[(11 - i) * 32 +: 32], got[(11 - i) * 32 +: 32]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    eye_row_t rows[$];
    eye_row_t r;
    lav_res_t z0;
    z0 = '0;
    cam_regs = '{0, 0, 0, 0, ONE, 0};

    r = '{x: 0, y: 0, z: 0, typed: 1'b1, res: z0};
    rows.push_back(r);
    r.y = NEG_ONE;
    r.res.back_y = NEG_ONE;
    r.res.shift_z = NEG_ONE;
    rows.push_back(r);
    r.y = ONE;
    r.res.back_y = ONE;
    rows.push_back(r);
    r.typed = 1'b0;
    r.res = z0;
    r.x = MINV; r.y = MINV; r.z = MINV; rows.push_back(r);
    r.x = MAXV; r.y = MAXV; r.z = MAXV; rows.push_back(r);
    r.x = MINV; r.y = 0; r.z = MAXV; rows.push_back(r);
    r.x = ONE; r.y = 0; r.z = 0; rows.push_back(r);
    r.x = 0; r.y = 0; r.z = NEG_ONE; rows.push_back(r);
    r.x = 1; r.y = -1; r.z = 1; rows.push_back(r);
    r.x = MAXV; r.y = 0; r.z = 0; rows.push_back(r);
    r.x = 0; r.y = MINV; r.z = 1; rows.push_back(r);
    r.x = 32'h0003_0000; r.y = 32'hFFFE_0000; r.z = 32'h0004_8000; rows.push_back(r);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_eye(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].res);
    in_valid <= 1'b0;
    settle();

    set_camera($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    random_eyes(90);
    in_valid <= 1'b0;
    settle();

    set_camera(MAXV, MINV, MAXV, MINV, MAXV, 0);
    write_reg(3'd6, $urandom());
    write_reg(3'd7, $urandom());
    random_eyes(90);
    in_valid <= 1'b0;
    settle();

    set_camera($urandom_range(0, 32'h100000), NEG_ONE, 32'h7, 0, 0, 0);
    random_eyes(40);
    in_valid <= 1'b0;
    wait_empty();
    random_eyes(40);
    in_valid <= 1'b0;
    settle();

    set_camera(MINV, MAXV, MINV, NEG_ONE, 0, 0);
    random_eyes(45);
    in_valid <= 1'b0;
    settle();
    set_camera(32'h0002_0000, 0, NEG_ONE, 0, 0, ONE);
    random_eyes(45);
    in_valid <= 1'b0;
    settle();

    set_camera($urandom(), $urandom(), $urandom(), pick_word(), pick_word(), pick_word());
    random_eyes(90);
    in_valid <= 1'b0;
    settle();

    set_camera(0, 0, 0, 0, ONE, 0);
    quiet = 1'b1;
    random_eyes(110);
    in_valid <= 1'b0;
    settle();

    $display("Sent %0d eye positions and checked %0d view matrices.", items_sent, results_seen);
    $display("Settings covered random, extreme, zero and axis-aligned targets and up hints.");
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, matrix_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
